>>> design/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CCCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/cccb_pkg.sv
// ----------------------------------------------------------------------------
// cccb_pkg
// Types and constants of the character cell framebuffer blitter.
// ----------------------------------------------------------------------------
package cccb_pkg;

	localparam int CELL_PIXELS = 6;

	typedef enum logic [1:0] {
		CMD_READ = 2'd0,
		CMD_DRAW = 2'd1,
		CMD_FILL = 2'd2,
		CMD_COPY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_FONT = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	localparam logic [4:0] ROWS_RESET = 5'd24;
	localparam logic [6:0] COLS_RESET = 7'd80;
	localparam logic [3:0] FONT_RESET = 4'd11;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_EVAL,
		ST_R0,
		ST_R1,
		ST_R2,
		ST_LOAD,
		ST_BRD0,
		ST_BRD1,
		ST_BRD2,
		ST_BRD3,
		ST_BWR,
		ST_DONE
	} state_t;

endpackage

>>> design/cccb_ram.sv
// ----------------------------------------------------------------------------
// cccb_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cccb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> design/char_cell_framebuffer_blitter.sv
// ----------------------------------------------------------------------------
// char_cell_framebuffer_blitter
// Text-mode blitter over a one-bit framebuffer of character cells.
// ----------------------------------------------------------------------------
// Requests come in on in_valid/in_ready, one command per request, and each
// gives exactly one result on out_valid/out_ready (read_bits, status).
// Registers rows_in_use, cols_in_use and font_height sit on the APB port at
// byte addresses 0, 4 and 8; write them only while the block is idle.
// One request is worked at a time, byte by byte through the framebuffer RAM
// (one read and one write port). After the request is checked, a rejected
// command goes straight to its result; a read fetches the two bytes of the
// cell line; draw and fill read, merge and write back each byte touched (a
// draw touches one or two bytes, a fill every byte of the span); a copy first
// loads the whole source line into the line buffer and then merges every
// byte of the destination line.
// The per-byte read-modify-write through the single RAM sets the pace.
// After reset a clearing pass writes zero to SCREEN_LINES*LINE_BYTES bytes
// (21888 bytes at the default size), one per cycle; in_ready stays low.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted and parks until the output register is free.
// ----------------------------------------------------------------------------
module char_cell_framebuffer_blitter #(
	parameter int SCREEN_LINES = 342,
	parameter int LINE_BYTES   = 64,
	parameter int LEFT_MARGIN  = 16,
	parameter int TOP_MARGIN   = 39,
	parameter int CELL_LINES   = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [4:0]  row,
	input  logic [6:0]  col,
	input  logic [3:0]  line,
	input  logic [4:0]  dst_row,
	input  logic [6:0]  dst_col,
	input  logic [6:0]  count,
	input  logic [5:0]  glyph_bits,
	input  logic        underline,
	input  logic        crossout,
	input  logic        reverse_video,
	input  logic        blank_white,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  read_bits,
	output logic        status
);
	import cccb_pkg::*;

	localparam int FRAME_DEPTH = SCREEN_LINES * LINE_BYTES;
	localparam int FAW         = $clog2(FRAME_DEPTH);
	localparam int BAW         = $clog2(LINE_BYTES);
	localparam int KW          = $clog2(LINE_BYTES + 1);
	localparam int LINE_PIXELS = LINE_BYTES * 8;
	localparam int YMAX        = TOP_MARGIN + 31 * CELL_LINES + 15;
	localparam int YW          = $clog2((YMAX > SCREEN_LINES ? YMAX : SCREEN_LINES) + 1);
	localparam int XMAX        = LEFT_MARGIN + CELL_PIXELS * 255 + 8;
	localparam int XW          = $clog2((XMAX > LINE_PIXELS ? XMAX : LINE_PIXELS) + 1);
	localparam int SW          = XW + 2;
	localparam logic [4:0] LINE_LIMIT = 5'(CELL_LINES);
	localparam logic [4:0] UNDER_LINE = 5'(CELL_LINES - 1);
	localparam logic [4:0] CROSS_LINE = 5'(CELL_LINES - 5);

	// configuration
	logic [4:0] rows_q;
	logic [6:0] cols_q;
	logic [3:0] font_q;
	reg_idx_t   reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
			font_q <= FONT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_ROWS: rows_q <= pwdata[4:0];
				REG_COLS: cols_q <= pwdata[6:0];
				REG_FONT: font_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROWS: prdata = {27'd0, rows_q};
			REG_COLS: prdata = {25'd0, cols_q};
			REG_FONT: prdata = {28'd0, font_q};
			default:  prdata = 32'd0;
		endcase
	end

	// request fields
	cmd_t       cmd_q;
	logic [4:0] row_q, drow_q;
	logic [6:0] col_q, dcol_q, cnt_q;
	logic [3:0] line_q;
	logic [5:0] glyph_q;
	logic       under_q, cross_q, rev_q, white_q;

	// derived geometry
	logic [YW-1:0]  ys_q, yd_q;
	logic [XW-1:0]  xc_q, xd_q, xce_q, xde_q;
	logic [XW-1:0]  lo_q, hi_q;
	logic [FAW-1:0] soff_q, doff_q;
	logic [KW-1:0]  k_q, klast_q, kfirst_q;
	logic [SW-1:0]  sdelta_q;
	logic [15:0]    w_q;
	logic [7:0]     old_q, hib_q, lob_q, b0_q;
	logic [5:0]     res_rd_q;
	logic           res_st_q;
	logic [FAW-1:0] clr_q;

	state_t state_q, state_d;

	// memories
	logic           f_we;
	logic [FAW-1:0] f_waddr, f_raddr;
	logic [7:0]     f_wdata, f_rdata;
	logic           b_we;
	logic [BAW-1:0] b_waddr, b_raddr;
	logic [7:0]     b_rdata;

	cccb_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	cccb_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_linebuf (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (f_rdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	function automatic logic [XW-1:0] cell_x(input logic [7:0] n);
		return XW'(LEFT_MARGIN) + XW'(n) * XW'(CELL_PIXELS);
	endfunction

	function automatic logic [YW-1:0] line_y(input logic [4:0] r, input logic [3:0] l);
		return YW'(TOP_MARGIN) + YW'(r) * YW'(CELL_LINES) + YW'(l);
	endfunction

	// validity checks
	logic [7:0] end_c1, end_cc, end_dc;
	logic       src_ok, dst_ok, cmd_ok;
	logic [5:0] px;

	assign end_c1 = {1'b0, col_q} + 8'd1;
	assign end_cc = {1'b0, col_q} + {1'b0, cnt_q};
	assign end_dc = {1'b0, dcol_q} + {1'b0, cnt_q};
	assign src_ok = ({1'b0, line_q} < LINE_LIMIT) && (row_q < rows_q)
		&& (ys_q < YW'(SCREEN_LINES));
	assign dst_ok = ({1'b0, line_q} < LINE_LIMIT) && (drow_q < rows_q)
		&& (yd_q < YW'(SCREEN_LINES));

	always_comb begin
		unique case (cmd_q)
			CMD_READ, CMD_DRAW: cmd_ok = src_ok && (end_c1 <= {1'b0, cols_q})
				&& (xc_q + XW'(CELL_PIXELS) <= XW'(LINE_PIXELS));
			CMD_FILL: cmd_ok = src_ok && (dcol_q > col_q) && (dcol_q <= cols_q)
				&& (xd_q <= XW'(LINE_PIXELS));
			default: cmd_ok = src_ok && dst_ok
				&& (end_cc <= {1'b0, cols_q}) && (xce_q <= XW'(LINE_PIXELS))
				&& (end_dc <= {1'b0, cols_q}) && (xde_q <= XW'(LINE_PIXELS));
		endcase
	end

	always_comb begin
		px = white_q ? 6'h3f : 6'h00;
		if (line_q < font_q) begin
			px = rev_q ? ~glyph_q : glyph_q;
		end
		if (under_q && ({1'b0, line_q} == UNDER_LINE) && !rev_q) begin
			px = px ^ 6'h3f;
		end
		if (cross_q && ({1'b0, line_q} == CROSS_LINE)) begin
			px = rev_q ? 6'h00 : 6'h3f;
		end
	end

	// per-byte merge
	logic [7:0]    mask, newv, val;
	logic [XW-1:0] xbase;
	logic [SW-1:0] sbase;
	logic [BAW-1:0] m_addr;
	logic [15:0]   pair;

	assign xbase  = XW'({k_q, 3'b000});
	assign sbase  = SW'({k_q, 3'b000}) + sdelta_q;
	assign m_addr = sbase[BAW+2:3];
	assign pair   = {hib_q, lob_q} << sbase[2:0];

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			mask[7-j] = (xbase + XW'(j) >= lo_q) && (xbase + XW'(j) < hi_q);
		end
	end

	always_comb begin
		unique case (cmd_q)
			CMD_DRAW: val = (k_q == kfirst_q) ? w_q[15:8] : w_q[7:0];
			CMD_FILL: val = white_q ? 8'hff : 8'h00;
			default:  val = pair[15:8];
		endcase
		newv = (old_q & ~mask) | (val & mask);
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	logic [15:0] rd_pair;
	assign rd_pair = {b0_q, f_rdata} << xc_q[2:0];

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		f_we     = 1'b0;
		f_waddr  = doff_q + FAW'(k_q);
		f_wdata  = newv;
		f_raddr  = soff_q + FAW'(k_q);
		b_we     = 1'b0;
		b_waddr  = k_q[BAW-1:0] - BAW'(1);
		b_raddr  = k_q[BAW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				f_we    = 1'b1;
				f_waddr = clr_q;
				f_wdata = 8'h00;
				if (clr_q == FAW'(FRAME_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: state_d = ST_EVAL;
			ST_EVAL: begin
				if (!cmd_ok) begin
					state_d = ST_DONE;
				end else begin
					unique case (cmd_q)
						CMD_READ: state_d = ST_R0;
						CMD_COPY: state_d = ST_LOAD;
						default:  state_d = ST_BRD0;
					endcase
				end
			end
			ST_R0: state_d = ST_R1;
			ST_R1: begin
				f_raddr = soff_q + FAW'(k_q) + FAW'(1);
				state_d = ST_R2;
			end
			ST_R2: state_d = ST_DONE;
			ST_LOAD: begin
				// read line byte k, store byte k-1 returned from last cycle
				b_we = (k_q != '0);
				if (k_q == KW'(LINE_BYTES)) begin
					state_d = ST_BRD0;
				end
			end
			ST_BRD0: begin
				f_raddr = doff_q + FAW'(k_q);
				state_d = ST_BRD1;
			end
			ST_BRD1: begin
				b_raddr = m_addr;
				state_d = (cmd_q == CMD_COPY) ? ST_BRD2 : ST_BWR;
			end
			ST_BRD2: begin
				b_raddr = m_addr + BAW'(1);
				state_d = ST_BRD3;
			end
			ST_BRD3: state_d = ST_BWR;
			ST_BWR: begin
				f_we    = 1'b1;
				state_d = (k_q == klast_q) ? ST_DONE : ST_BRD0;
			end
			ST_DONE: begin
				if (!out_valid || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + FAW'(1);
			end
			if (state_q == ST_DONE && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid || out_ready)) begin
			read_bits <= res_rd_q;
			status    <= res_st_q;
		end
		case (state_q)
			ST_IDLE: begin
				cmd_q   <= cmd_t'(cmd);
				row_q   <= row;
				col_q   <= col;
				line_q  <= line;
				drow_q  <= dst_row;
				dcol_q  <= dst_col;
				cnt_q   <= count;
				glyph_q <= glyph_bits;
				under_q <= underline;
				cross_q <= crossout;
				rev_q   <= reverse_video;
				white_q <= blank_white;
			end
			ST_CALC: begin
				ys_q  <= line_y(row_q, line_q);
				yd_q  <= line_y(drow_q, line_q);
				xc_q  <= cell_x({1'b0, col_q});
				xd_q  <= cell_x({1'b0, dcol_q});
				xce_q <= cell_x(end_cc);
				xde_q <= cell_x(end_dc);
			end
			ST_EVAL: begin
				res_rd_q <= 6'd0;
				res_st_q <= !cmd_ok;
				soff_q   <= FAW'(ys_q) * FAW'(LINE_BYTES);
				doff_q   <= (cmd_q == CMD_COPY) ? FAW'(yd_q) * FAW'(LINE_BYTES)
					: FAW'(ys_q) * FAW'(LINE_BYTES);
				sdelta_q <= SW'(xc_q) - SW'(xd_q);
				w_q      <= {px, 10'd0} >> xc_q[2:0];
				unique case (cmd_q)
					CMD_READ, CMD_DRAW: begin
						lo_q <= xc_q;
						hi_q <= xc_q + XW'(CELL_PIXELS);
						k_q  <= KW'(xc_q >> 3);
						kfirst_q <= KW'(xc_q >> 3);
						klast_q  <= KW'((xc_q + XW'(CELL_PIXELS - 1)) >> 3);
					end
					CMD_FILL: begin
						lo_q <= xc_q;
						hi_q <= xd_q;
						k_q  <= KW'(xc_q >> 3);
						kfirst_q <= KW'(xc_q >> 3);
						klast_q  <= KW'((xd_q - XW'(1)) >> 3);
					end
					default: begin
						lo_q <= xd_q;
						hi_q <= xde_q;
						k_q  <= '0;
						kfirst_q <= '0;
						klast_q  <= KW'(LINE_BYTES - 1);
					end
				endcase
			end
			ST_R1: b0_q <= f_rdata;
			ST_R2: res_rd_q <= rd_pair[15:10];
			ST_LOAD: k_q <= (k_q == KW'(LINE_BYTES)) ? '0 : k_q + KW'(1);
			ST_BRD1: old_q <= (cmd_q == CMD_COPY) ? b_rdata : f_rdata;
			ST_BRD2: hib_q <= b_rdata;
			ST_BRD3: lob_q <= b_rdata;
			ST_BWR: k_q <= k_q + KW'(1);
			default: ;
		endcase
	end
endmodule

>>> design/cccb_checker.sv
// ----------------------------------------------------------------------------
// cccb_checker
// Port-level checks of the blitter's request and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cccb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] read_bits,
	input logic       status,
	input logic       pready
);
	// a stalled result holds
	`CCCB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_bits) && $stable(status))
	// a rejected request never returns pixels
	`CCCB_ASSERT_NOW(a_reject_zero, clk, arst_n, out_valid && status, read_bits == 6'd0)
	// one request at a time: busy right after an accept
	`CCCB_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready)
	// a result never appears in the cycle right after an accept
	`CCCB_ASSERT_NEXT(a_no_early, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid)
	// register port never stalls
	`CCCB_ASSERT_NOW(a_pready, clk, arst_n, 1'b1, pready)
endmodule

bind char_cell_framebuffer_blitter cccb_checker u_cccb_checker (.*);
